### src/shc_pkg.sv
// types, key codes and helpers shared by the settable clock modules
package shc_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam logic [7:0] KEY_CLEAR  = 8'h63;
    localparam logic [7:0] KEY_RIGHT  = 8'h36;
    localparam logic [7:0] KEY_LEFT   = 8'h34;
    localparam logic [7:0] KEY_UP     = 8'h38;
    localparam logic [7:0] KEY_DOWN   = 8'h32;
    localparam logic [7:0] KEY_START  = 8'h39;
    localparam logic [7:0] KEY_PAUSE  = 8'h37;
    localparam logic [7:0] KEY_RESUME = 8'h33;
    localparam logic [7:0] KEY_STOP   = 8'h31;

    localparam logic [2:0] CUR_HT = 3'd0;
    localparam logic [2:0] CUR_HU = 3'd1;
    localparam logic [2:0] CUR_MT = 3'd2;
    localparam logic [2:0] CUR_MU = 3'd3;
    localparam logic [2:0] CUR_ST = 3'd4;
    localparam logic [2:0] CUR_SU = 3'd5;

    localparam logic [1:0] TOP_HT = 2'd2;
    localparam logic [3:0] TOP_UNITS = 4'd9;
    localparam logic [2:0] TOP_TENS = 3'd5;
    localparam logic [5:0] LAST_MS = 6'd59;
    localparam logic [4:0] LAST_H  = 5'd23;

    typedef enum logic [1:0] {
        MODE_EDIT  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0] ht;
        logic [3:0] hu;
        logic [2:0] mt;
        logic [3:0] mu;
        logic [2:0] st;
        logic [3:0] su;
        logic [2:0] cursor;
        logic [4:0] run_h;
        logic [5:0] run_m;
        logic [5:0] run_s;
        t_mode      mode;
    } t_state;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] cursor;
        logic [1:0] mode;
    } t_view;

    // tens * 10 + units as shifts and adds
    function automatic logic [5:0] join_digits(input logic [2:0] tens, input logic [3:0] units);
        logic [5:0] t;
        t = {3'b000, tens};
        return (t << 3) + (t << 1) + {2'b00, units};
    endfunction

endpackage

### src/shc_step.sv
// next clock state and shown view for one accepted transfer
module shc_step (
    input  shc_pkg::t_state i_cur,
    input  logic            i_opcode,
    input  logic [7:0]      i_key_code,
    output shc_pkg::t_state o_next,
    output shc_pkg::t_view  o_view
);

    shc_pkg::t_mode n_mode;
    shc_pkg::t_state n_st;
    logic is_key;
    logic [5:0] h_join;

    assign is_key = (i_opcode == shc_pkg::OP_KEY);

    // next mode
    always_comb begin
        n_mode = i_cur.mode;
        case (i_cur.mode)
            shc_pkg::MODE_RUN: begin
                if (is_key && i_key_code == shc_pkg::KEY_PAUSE) begin
                    n_mode = shc_pkg::MODE_PAUSE;
                end else if (is_key && i_key_code == shc_pkg::KEY_STOP) begin
                    n_mode = shc_pkg::MODE_EDIT;
                end
            end
            shc_pkg::MODE_PAUSE: begin
                if (is_key && i_key_code == shc_pkg::KEY_RESUME) begin
                    n_mode = shc_pkg::MODE_RUN;
                end else if (is_key && i_key_code == shc_pkg::KEY_STOP) begin
                    n_mode = shc_pkg::MODE_EDIT;
                end
            end
            default: begin
                if (is_key && i_key_code == shc_pkg::KEY_START) begin
                    n_mode = shc_pkg::MODE_RUN;
                end
            end
        endcase
    end

    // digits, cursor and running time
    always_comb begin
        n_st = i_cur;
        h_join = shc_pkg::join_digits({1'b0, i_cur.ht}, i_cur.hu);
        case (i_cur.mode)
            shc_pkg::MODE_RUN: begin
                if (!is_key) begin
                    if (i_cur.run_s < shc_pkg::LAST_MS) begin
                        n_st.run_s = i_cur.run_s + 6'd1;
                    end else begin
                        n_st.run_s = '0;
                        if (i_cur.run_m < shc_pkg::LAST_MS) begin
                            n_st.run_m = i_cur.run_m + 6'd1;
                        end else begin
                            n_st.run_m = '0;
                            if (i_cur.run_h < shc_pkg::LAST_H) begin
                                n_st.run_h = i_cur.run_h + 5'd1;
                            end else begin
                                n_st.run_h = '0;
                            end
                        end
                    end
                end else if (i_key_code == shc_pkg::KEY_STOP) begin
                    n_st.ht = '0; n_st.hu = '0; n_st.mt = '0;
                    n_st.mu = '0; n_st.st = '0; n_st.su = '0;
                    n_st.run_h = '0; n_st.run_m = '0; n_st.run_s = '0;
                end
            end
            shc_pkg::MODE_PAUSE: begin
                if (is_key && i_key_code == shc_pkg::KEY_STOP) begin
                    n_st.ht = '0; n_st.hu = '0; n_st.mt = '0;
                    n_st.mu = '0; n_st.st = '0; n_st.su = '0;
                    n_st.run_h = '0; n_st.run_m = '0; n_st.run_s = '0;
                end
            end
            default: begin
                if (is_key) begin
                    case (i_key_code)
                        shc_pkg::KEY_CLEAR: begin
                            n_st.ht = '0; n_st.hu = '0; n_st.mt = '0;
                            n_st.mu = '0; n_st.st = '0; n_st.su = '0;
                            n_st.run_h = '0; n_st.run_m = '0; n_st.run_s = '0;
                            n_st.cursor = shc_pkg::CUR_HT;
                        end
                        shc_pkg::KEY_RIGHT: begin
                            n_st.cursor = (i_cur.cursor == shc_pkg::CUR_SU) ? shc_pkg::CUR_HT
                                                                            : i_cur.cursor + 3'd1;
                        end
                        shc_pkg::KEY_LEFT: begin
                            n_st.cursor = (i_cur.cursor == shc_pkg::CUR_HT) ? shc_pkg::CUR_SU
                                                                            : i_cur.cursor - 3'd1;
                        end
                        shc_pkg::KEY_UP: begin
                            case (i_cur.cursor)
                                shc_pkg::CUR_HT: n_st.ht = (i_cur.ht >= shc_pkg::TOP_HT)
                                                         ? 2'd0 : i_cur.ht + 2'd1;
                                shc_pkg::CUR_HU: n_st.hu = (i_cur.hu >= shc_pkg::TOP_UNITS)
                                                         ? 4'd0 : i_cur.hu + 4'd1;
                                shc_pkg::CUR_MT: n_st.mt = (i_cur.mt >= shc_pkg::TOP_TENS)
                                                         ? 3'd0 : i_cur.mt + 3'd1;
                                shc_pkg::CUR_MU: n_st.mu = (i_cur.mu >= shc_pkg::TOP_UNITS)
                                                         ? 4'd0 : i_cur.mu + 4'd1;
                                shc_pkg::CUR_ST: n_st.st = (i_cur.st >= shc_pkg::TOP_TENS)
                                                         ? 3'd0 : i_cur.st + 3'd1;
                                shc_pkg::CUR_SU: n_st.su = (i_cur.su >= shc_pkg::TOP_UNITS)
                                                         ? 4'd0 : i_cur.su + 4'd1;
                                default: ;
                            endcase
                        end
                        shc_pkg::KEY_DOWN: begin
                            case (i_cur.cursor)
                                shc_pkg::CUR_HT: n_st.ht = (i_cur.ht == 2'd0)
                                                         ? shc_pkg::TOP_HT : i_cur.ht - 2'd1;
                                shc_pkg::CUR_HU: n_st.hu = (i_cur.hu == 4'd0)
                                                         ? shc_pkg::TOP_UNITS : i_cur.hu - 4'd1;
                                shc_pkg::CUR_MT: n_st.mt = (i_cur.mt == 3'd0)
                                                         ? shc_pkg::TOP_TENS : i_cur.mt - 3'd1;
                                shc_pkg::CUR_MU: n_st.mu = (i_cur.mu == 4'd0)
                                                         ? shc_pkg::TOP_UNITS : i_cur.mu - 4'd1;
                                shc_pkg::CUR_ST: n_st.st = (i_cur.st == 3'd0)
                                                         ? shc_pkg::TOP_TENS : i_cur.st - 3'd1;
                                shc_pkg::CUR_SU: n_st.su = (i_cur.su == 4'd0)
                                                         ? shc_pkg::TOP_UNITS : i_cur.su - 4'd1;
                                default: ;
                            endcase
                        end
                        shc_pkg::KEY_START: begin
                            n_st.run_h = h_join[4:0];
                            n_st.run_m = shc_pkg::join_digits(i_cur.mt, i_cur.mu);
                            n_st.run_s = shc_pkg::join_digits(i_cur.st, i_cur.su);
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        n_st.mode = n_mode;
    end

    assign o_next = n_st;

    // shown view from the next state
    always_comb begin
        logic [5:0] hj;
        hj = shc_pkg::join_digits({1'b0, n_st.ht}, n_st.hu);
        if (n_st.mode == shc_pkg::MODE_RUN || n_st.mode == shc_pkg::MODE_PAUSE) begin
            o_view.hours   = n_st.run_h;
            o_view.minutes = n_st.run_m;
            o_view.seconds = n_st.run_s;
        end else begin
            o_view.hours   = hj[4:0];
            o_view.minutes = shc_pkg::join_digits(n_st.mt, n_st.mu);
            o_view.seconds = shc_pkg::join_digits(n_st.st, n_st.su);
        end
        o_view.cursor = n_st.cursor;
        o_view.mode   = n_st.mode;
    end

endmodule

### src/settable_hms_clock.sv
// settable 24-hour clock top level: input register, clock state, result register
//
// channel   valid         stall         payload
// input     i_in_valid    o_in_stall    i_opcode, i_key_code
// result    o_out_valid   i_out_stall   o_hours, o_minutes, o_seconds_out, o_cursor, o_mode
//
// one transfer per cycle unless stalled; a result is registered after the input register
// the clock state is updated as a transfer leaves the input register
// reset clears the time, digits, cursor, mode and both valid flags
// a stalled result holds; the input register takes one more transfer, then stalls
module settable_hms_clock (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_key_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_hours,
    output logic [5:0] o_minutes,
    output logic [5:0] o_seconds_out,
    output logic [2:0] o_cursor,
    output logic [1:0] o_mode
);

    logic            r_in_valid;
    logic            r_opcode;
    logic [7:0]      r_key_code;
    shc_pkg::t_state r_state;
    shc_pkg::t_state n_state;
    shc_pkg::t_view  n_view;
    shc_pkg::t_view  r_view;
    logic            r_out_valid;
    logic            out_free;
    logic            advance;
    logic            in_ready;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && out_free;
    assign in_ready = !r_in_valid || advance;
    assign o_in_stall = !in_ready;

    shc_step u_step (
        .i_cur      (r_state),
        .i_opcode   (r_opcode),
        .i_key_code (r_key_code),
        .o_next     (n_state),
        .o_view     (n_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_opcode   <= i_opcode;
            r_key_code <= i_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{ht: '0, hu: '0, mt: '0, mu: '0, st: '0, su: '0,
                         cursor: shc_pkg::CUR_HT, run_h: '0, run_m: '0, run_s: '0,
                         mode: shc_pkg::MODE_EDIT};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_view <= n_view;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hours       = r_view.hours;
    assign o_minutes     = r_view.minutes;
    assign o_seconds_out = r_view.seconds;
    assign o_cursor      = r_view.cursor;
    assign o_mode        = r_view.mode;

endmodule

### verif/tb.sv
// testbench for settable_hms_clock: queued stimulus, clock predictor, result checker
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic       op;
        logic [7:0] code;
    } t_key_event;

    typedef struct packed {
        logic [5:0][3:0] dig;
        logic [2:0]      cur;
        logic [4:0]      hh;
        logic [5:0]      mm;
        logic [5:0]      ss;
        shc_pkg::t_mode  md;
    } t_clk_regs;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_opcode = shc_pkg::OP_TICK;
    logic [7:0] i_key_code = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [4:0] o_hours;
    logic [5:0] o_minutes;
    logic [5:0] o_seconds_out;
    logic [2:0] o_cursor;
    logic [1:0] o_mode;

    t_key_event     pending[$];
    shc_pkg::t_view expected_views[$];
    t_clk_regs      clock_model = '0;
    t_clk_regs      plan_state = '0;
    logic           hold_off = 1'b0;
    bit             tx_steady = 1'b0;
    bit             rx_steady = 1'b0;
    int             tx_wait = 0;
    int             rx_wait = 0;
    int             sent = 0;
    int             ticks_sent = 0;
    int             checked = 0;
    int             mismatches = 0;
    int             backed_up = 0;

    settable_hms_clock DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_key_code    (i_key_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hours       (o_hours),
        .o_minutes     (o_minutes),
        .o_seconds_out (o_seconds_out),
        .o_cursor      (o_cursor),
        .o_mode        (o_mode)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [3:0] digit_top(input logic [2:0] c);
        case (c)
            shc_pkg::CUR_HT:                  return {2'b00, shc_pkg::TOP_HT};
            shc_pkg::CUR_MT, shc_pkg::CUR_ST: return {1'b0, shc_pkg::TOP_TENS};
            default:                          return shc_pkg::TOP_UNITS;
        endcase
    endfunction

    function automatic t_clk_regs wipe_time(input t_clk_regs s);
        t_clk_regs n;
        n = s;
        n.dig = '0;
        n.hh = '0;
        n.mm = '0;
        n.ss = '0;
        return n;
    endfunction

    function automatic t_clk_regs step_clock(input t_clk_regs s, input logic op,
                                             input logic [7:0] key);
        t_clk_regs n;
        logic [2:0] c;
        n = s;
        c = s.cur;
        case (s.md)
            shc_pkg::MODE_RUN: begin
                if (op == shc_pkg::OP_TICK) begin
                    if (n.ss < shc_pkg::LAST_MS) begin
                        n.ss = n.ss + 6'd1;
                    end else begin
                        n.ss = '0;
                        if (n.mm < shc_pkg::LAST_MS) begin
                            n.mm = n.mm + 6'd1;
                        end else begin
                            n.mm = '0;
                            n.hh = (n.hh < shc_pkg::LAST_H) ? n.hh + 5'd1 : 5'd0;
                        end
                    end
                end else if (key == shc_pkg::KEY_PAUSE) begin
                    n.md = shc_pkg::MODE_PAUSE;
                end else if (key == shc_pkg::KEY_STOP) begin
                    n = wipe_time(n);
                    n.md = shc_pkg::MODE_EDIT;
                end
            end
            shc_pkg::MODE_PAUSE: begin
                if (op == shc_pkg::OP_KEY && key == shc_pkg::KEY_RESUME) begin
                    n.md = shc_pkg::MODE_RUN;
                end else if (op == shc_pkg::OP_KEY && key == shc_pkg::KEY_STOP) begin
                    n = wipe_time(n);
                    n.md = shc_pkg::MODE_EDIT;
                end
            end
            default: begin
                if (op == shc_pkg::OP_KEY) begin
                    case (key)
                        shc_pkg::KEY_CLEAR: begin
                            n = wipe_time(n);
                            n.cur = shc_pkg::CUR_HT;
                        end
                        shc_pkg::KEY_RIGHT: begin
                            n.cur = (c == shc_pkg::CUR_SU) ? shc_pkg::CUR_HT : c + 3'd1;
                        end
                        shc_pkg::KEY_LEFT: begin
                            n.cur = (c == shc_pkg::CUR_HT) ? shc_pkg::CUR_SU : c - 3'd1;
                        end
                        shc_pkg::KEY_UP: begin
                            n.dig[c] = (s.dig[c] >= digit_top(c)) ? 4'd0 : s.dig[c] + 4'd1;
                        end
                        shc_pkg::KEY_DOWN: begin
                            n.dig[c] = (s.dig[c] == 4'd0) ? digit_top(c) : s.dig[c] - 4'd1;
                        end
                        shc_pkg::KEY_START: begin
                            n.hh = 5'(10 * s.dig[shc_pkg::CUR_HT] + s.dig[shc_pkg::CUR_HU]);
                            n.mm = 6'(10 * s.dig[shc_pkg::CUR_MT] + s.dig[shc_pkg::CUR_MU]);
                            n.ss = 6'(10 * s.dig[shc_pkg::CUR_ST] + s.dig[shc_pkg::CUR_SU]);
                            n.md = shc_pkg::MODE_RUN;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        return n;
    endfunction

    function automatic shc_pkg::t_view show_clock(input t_clk_regs s);
        shc_pkg::t_view v;
        int h, m, sec;
        if (s.md == shc_pkg::MODE_RUN || s.md == shc_pkg::MODE_PAUSE) begin
            h = s.hh;
            m = s.mm;
            sec = s.ss;
        end else begin
            h = 10 * s.dig[shc_pkg::CUR_HT] + s.dig[shc_pkg::CUR_HU];
            m = 10 * s.dig[shc_pkg::CUR_MT] + s.dig[shc_pkg::CUR_MU];
            sec = 10 * s.dig[shc_pkg::CUR_ST] + s.dig[shc_pkg::CUR_SU];
        end
        v.hours = h[4:0];
        v.minutes = m[5:0];
        v.seconds = sec[5:0];
        v.cursor = s.cur;
        v.mode = s.md;
        return v;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_event(input logic op, input logic [7:0] code);
        t_key_event ev;
        plan_state = step_clock(plan_state, op, code);
        ev.op = op;
        ev.code = code;
        pending.push_back(ev);
    endtask

    task automatic queue_key(input logic [7:0] code);
        queue_event(shc_pkg::OP_KEY, code);
    endtask

    task automatic queue_tick();
        queue_event(shc_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // stop, clear, set a time, usually start, then run with ticks, pause/resume and random keys
    task automatic add_session();
        int r;
        queue_key(shc_pkg::KEY_STOP);
        queue_key(shc_pkg::KEY_CLEAR);
        if ($urandom_range(0, 1) == 1) begin
            for (int d = 0; d < 6; d++) begin
                repeat ((d == 1) ? $urandom_range(0, 9) : $urandom_range(0, 3))
                    queue_key(shc_pkg::KEY_DOWN);
                queue_key(shc_pkg::KEY_RIGHT);
            end
        end else begin
            repeat ($urandom_range(3, 20)) begin
                case ($urandom_range(0, 5))
                    0:       queue_key(shc_pkg::KEY_RIGHT);
                    1:       queue_key(shc_pkg::KEY_LEFT);
                    2, 3:    queue_key(shc_pkg::KEY_UP);
                    default: queue_key(shc_pkg::KEY_DOWN);
                endcase
            end
        end
        if ($urandom_range(0, 9) != 0) queue_key(shc_pkg::KEY_START);
        repeat ($urandom_range(5, 120)) begin
            r = $urandom_range(0, 99);
            if (r < 85) queue_tick();
            else if (r < 90) queue_key(shc_pkg::KEY_PAUSE);
            else if (r < 95) queue_key(shc_pkg::KEY_RESUME);
            else queue_key(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at result %0d, %s: got %0d, expected %0d",
                     checked, what, got, want);
    endtask

    always @(posedge i_clk) begin : drive
        t_key_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                clock_model = step_clock(clock_model, i_opcode, i_key_code);
                expected_views.push_back(show_clock(clock_model));
                sent++;
                if (i_opcode == shc_pkg::OP_TICK) ticks_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    ev = pending.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode <= ev.op;
                    i_key_code <= ev.code;
                    tx_wait = pick_gap(tx_steady);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 299) == 0) tx_steady = !tx_steady;
        end
    end

    always @(posedge i_clk) begin : observe
        shc_pkg::t_view want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_views.size() == 0) begin
                flag_mismatch("unexpected result, hours", o_hours, -1);
            end else begin
                want = expected_views.pop_front();
                if (o_hours !== want.hours) flag_mismatch("hours", o_hours, want.hours);
                if (o_minutes !== want.minutes)
                    flag_mismatch("minutes", o_minutes, want.minutes);
                if (o_seconds_out !== want.seconds)
                    flag_mismatch("seconds", o_seconds_out, want.seconds);
                if (o_cursor !== want.cursor) flag_mismatch("cursor", o_cursor, want.cursor);
                if (o_mode !== want.mode) flag_mismatch("mode", o_mode, want.mode);
                checked++;
            end
        end
        if (hold_off && i_in_valid && o_in_stall) backed_up++;
        if (rx_wait > 0) rx_wait--;
        else if (!rx_steady && $urandom_range(0, 2) == 0) rx_wait = pick_gap(1'b0);
        i_out_stall <= hold_off || (rx_wait > 0);
        if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        while (sent < 400) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        // set 23:59:59 and roll over to midnight
        queue_key(shc_pkg::KEY_DOWN);
        queue_key(shc_pkg::KEY_RIGHT);
        repeat (3) queue_key(shc_pkg::KEY_UP);
        for (int d = 2; d < 6; d++) begin
            queue_key(shc_pkg::KEY_RIGHT);
            queue_key(shc_pkg::KEY_DOWN);
        end
        queue_key(shc_pkg::KEY_START);
        queue_tick();
        queue_key(shc_pkg::KEY_PAUSE);
        queue_tick();
        queue_key(8'hFF);
        queue_key(shc_pkg::KEY_RESUME);
        queue_tick();
        queue_key(shc_pkg::KEY_STOP);
        queue_key(shc_pkg::KEY_RIGHT);
        queue_key(shc_pkg::KEY_LEFT);
        queue_key(shc_pkg::KEY_UP);
        queue_key(shc_pkg::KEY_CLEAR);
        queue_key(8'h00);
        queue_event(shc_pkg::OP_TICK, 8'hFF);
        queue_key(shc_pkg::KEY_UP);
        while (pending.size() < 1850) add_session();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid || expected_views.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d input transfers (%0d ticks), %0d results checked",
                 sent, ticks_sent, checked);
        $display("input held back for %0d cycles during the long output hold-off", backed_up);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
